// ===== hw/rtl/normal_map_to_height_integrator_assert.svh =====
// Assertion macros for the normal map height integrator
`ifndef NORMAL_MAP_TO_HEIGHT_INTEGRATOR_ASSERT_SVH
`define NORMAL_MAP_TO_HEIGHT_INTEGRATOR_ASSERT_SVH

// property holds on every clock edge outside reset
`define NMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define NMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/nmh_pkg.sv =====
// ----------------------------------------------------------------------------
// nmh_pkg
// Shared constants and types of the normal map height integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nmh_pkg;
  localparam int CompBits   = 16;
  localparam int MaxWidth   = 4096;
  localparam int MaxHeight  = 4096;
  localparam int ColBits    = 12;
  localparam int DimBits    = 13;
  localparam int SumBits    = 48;
  localparam int SlopeBits  = 32;
  localparam int NumBits    = 34;   // |c| * 2^16, plus sign
  localparam int DenBits    = 17;   // nz, positive, up to 65534
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  localparam logic signed [SumBits-1:0] Sat48Max = {1'b0, {(SumBits-1){1'b1}}};
  localparam logic signed [SumBits-1:0] Sat48Min = {1'b1, {(SumBits-1){1'b0}}};

  // classified item from the front to the back
  typedef struct packed {
    logic                        active;  // accumulates (not row 0 / col 0)
    logic                        row0;
    logic                        col0;
    logic [ColBits-1:0]          col;
    logic                        eor;
    logic                        eof;
    logic signed [SlopeBits-1:0] sx;
    logic signed [SlopeBits-1:0] sy;
  } work_t;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } div_state_t;

  function automatic logic signed [SumBits-1:0] sat_add(
    input logic signed [SumBits-1:0] a,
    input logic signed [SumBits-1:0] b
  );
    logic signed [SumBits:0] s;
    s = {a[SumBits-1], a} + {b[SumBits-1], b};
    if (s[SumBits] != s[SumBits-1]) begin
      return s[SumBits] ? Sat48Min : Sat48Max;
    end
    return s[SumBits-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/nmh_stream_if.sv =====
// ----------------------------------------------------------------------------
// nmh_pixel_if / nmh_height_if
// Valid/ready channels for normal pixels in and heights out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface nmh_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] normal_x;
  logic [15:0] normal_y;
  logic [15:0] normal_z;
  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface nmh_height_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] height_value;
  logic               end_of_row;
  logic               end_of_frame;
  modport source (output valid, height_value, end_of_row, end_of_frame, input ready);
  modport sink   (input valid, height_value, end_of_row, end_of_frame, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/nmh_divider.sv =====
// ----------------------------------------------------------------------------
// nmh_divider
// Restoring divider: signed numerator by positive denominator, one quotient
// bit a cycle, truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nmh_divider (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [nmh_pkg::NumBits-1:0]   num,
  input  wire logic        [nmh_pkg::DenBits-1:0]   den,
  output logic                                      done,
  output logic signed [nmh_pkg::NumBits-1:0]        quot
);
  localparam int MagBits = nmh_pkg::NumBits - 1;

  logic [MagBits-1:0]         q;
  logic [nmh_pkg::DenBits-1:0] rem;
  logic [nmh_pkg::DenBits-1:0] d;
  logic                       neg;
  logic [5:0]                 cnt;
  logic                       busy;
  logic [nmh_pkg::DenBits:0]  trial;
  logic [MagBits-1:0]         mag;

  assign mag   = num[nmh_pkg::NumBits-1] ? MagBits'(-num) : num[MagBits-1:0];
  assign trial = {rem, q[MagBits-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 6'(MagBits);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below d, so it fits in DenBits
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q   <= mag;
      rem <= '0;
      d   <= den;
      neg <= num[nmh_pkg::NumBits-1];
    end else if (busy) begin
      if (!trial[nmh_pkg::DenBits]) begin
        rem <= trial[nmh_pkg::DenBits-1:0];
        q   <= {q[MagBits-2:0], 1'b1};
      end else begin
        rem <= {rem[nmh_pkg::DenBits-2:0], q[MagBits-1]};
        q   <= {q[MagBits-2:0], 1'b0};
      end
    end
  end

  assign quot = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule
`default_nettype wire

// ===== hw/rtl/nmh_front.sv =====
// ----------------------------------------------------------------------------
// nmh_front
// Takes pixels, tracks row and column, computes both slopes with a shared
// divider and hands classified items to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nmh_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [nmh_pkg::DimBits-1:0]   frame_width,
  input  wire logic [nmh_pkg::DimBits-1:0]   frame_height,
  nmh_pixel_if.sink                          pix,
  output logic                               push,
  output nmh_pkg::work_t                     push_item,
  input  wire logic                          queue_full
);
  nmh_pkg::div_state_t state;
  logic [nmh_pkg::ColBits-1:0] col, row;
  logic [nmh_pkg::DimBits-1:0] w, h;
  logic                        eor, eof, active;
  logic signed [nmh_pkg::NumBits-1:0] ny_num, div_num;
  logic [nmh_pkg::DenBits-1:0] nz_den, nz_live, div_den;
  logic                        second, div_start, div_done;
  logic signed [nmh_pkg::NumBits-1:0] quot;
  nmh_pkg::work_t              item;
  logic signed [nmh_pkg::SlopeBits-1:0] slope_sat;
  logic signed [17:0]          cx, cy, cz;

  assign w = (frame_width == '0) ? 13'd1
           : (frame_width > 13'(nmh_pkg::MaxWidth)) ? 13'(nmh_pkg::MaxWidth) : frame_width;
  assign h = (frame_height == '0) ? 13'd1
           : (frame_height > 13'(nmh_pkg::MaxHeight)) ? 13'(nmh_pkg::MaxHeight) : frame_height;
  assign eor = ({1'b0, col} + 13'd1) >= w;
  assign eof = eor && (({1'b0, row} + 13'd1) >= h);
  assign active = (row != '0) && (col != '0);

  assign cx = $signed({1'b0, pix.normal_x, 1'b0}) - 18'sd65536;
  assign cy = $signed({1'b0, pix.normal_y, 1'b0}) - 18'sd65536;
  assign cz = $signed({1'b0, pix.normal_z, 1'b0}) - 18'sd65536;

  assign nz_live = (cz < 18'sd1) ? 17'd1 : cz[16:0];

  // numerator is -c * 2^16; x pass starts off the live beat, y pass off registers
  assign div_num = (state == nmh_pkg::DV_IDLE) ? -($signed({{16{cx[17]}}, cx}) <<< 16)
                                               : ny_num;
  assign div_den = (state == nmh_pkg::DV_IDLE) ? nz_live : nz_den;

  assign pix.ready = (state == nmh_pkg::DV_IDLE);

  always_comb begin
    if (quot > $signed(34'sh07FFFFFFF)) slope_sat = 32'sh7FFFFFFF;
    else if (quot < -$signed(34'sh080000000)) slope_sat = 32'sh80000000;
    else slope_sat = quot[31:0];
  end

  nmh_divider u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot
  );

  assign div_start = (state == nmh_pkg::DV_IDLE && pix.valid && active) ||
                     (state == nmh_pkg::DV_RUN && div_done && !second);
  assign push = (state == nmh_pkg::DV_DONE) && !queue_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= nmh_pkg::DV_IDLE;
      col    <= '0;
      row    <= '0;
      second <= 1'b0;
    end else begin
      unique case (state)
        nmh_pkg::DV_IDLE: begin
          if (pix.valid) begin
            state  <= active ? nmh_pkg::DV_RUN : nmh_pkg::DV_DONE;
            second <= 1'b0;
            if (eor) begin
              col <= '0;
              row <= eof ? '0 : row + 12'd1;
            end else begin
              col <= col + 12'd1;
            end
          end
        end
        nmh_pkg::DV_RUN: begin
          if (div_done) begin
            if (second) state <= nmh_pkg::DV_DONE;
            else second <= 1'b1;
          end
        end
        nmh_pkg::DV_DONE: begin
          if (!queue_full) state <= nmh_pkg::DV_IDLE;
        end
        default: state <= nmh_pkg::DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == nmh_pkg::DV_IDLE && pix.valid) begin
      item.active <= active;
      item.row0   <= (row == '0);
      item.col0   <= (col == '0);
      item.col    <= col;
      item.eor    <= eor;
      item.eof    <= eof;
      item.sx     <= '0;
      item.sy     <= '0;
      ny_num      <= -($signed({{16{cy[17]}}, cy}) <<< 16);
      nz_den      <= nz_live;
    end else if (state == nmh_pkg::DV_RUN && div_done) begin
      if (second) item.sy <= slope_sat;
      else item.sx <= slope_sat;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/nmh_queue.sv =====
// ----------------------------------------------------------------------------
// nmh_queue
// Small FIFO between the slope front and the accumulator back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nmh_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire nmh_pkg::work_t push_item,
  output logic                full,
  input  wire logic           pop,
  output nmh_pkg::work_t      head,
  output logic                not_empty
);
  nmh_pkg::work_t slots [nmh_pkg::QueueDepth];
  logic [nmh_pkg::QueueAw-1:0] wptr, rptr;
  logic [nmh_pkg::QueueAw:0]   count;

  assign full      = (count == (nmh_pkg::QueueAw+1)'(nmh_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + (nmh_pkg::QueueAw)'(1);
      if (pop && not_empty) rptr <= rptr + (nmh_pkg::QueueAw)'(1);
      count <= count + (nmh_pkg::QueueAw+1)'(push && !full)
                     - (nmh_pkg::QueueAw+1)'(pop && not_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr] <= push_item;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/nmh_back.sv =====
// ----------------------------------------------------------------------------
// nmh_back
// Row sum and column line buffer; reads the column sum, adds, writes back
// and emits the height through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nmh_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire nmh_pkg::work_t head,
  input  wire logic          not_empty,
  output logic               pop,
  nmh_height_if.source       hout
);
  logic signed [nmh_pkg::SumBits-1:0] col_mem [nmh_pkg::MaxWidth];
  logic signed [nmh_pkg::SumBits-1:0] rd_data, row_acc, new_col, new_row;
  nmh_pkg::work_t cur;
  logic           stage;       // item read, memory data arrives
  logic           out_free;
  logic           clearing;    // zeroing pass over the line buffer after reset
  logic [nmh_pkg::ColBits-1:0] clr_addr;

  // one item in flight: read cycle, then update cycle once the output register is free
  assign out_free = !hout.valid || hout.ready;
  assign pop = not_empty && !stage && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 12'd1;
      if (clr_addr == 12'(nmh_pkg::MaxWidth - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rd_data <= col_mem[head.col];
    if (clearing)
      col_mem[clr_addr] <= '0;
    else if (stage && out_free && !cur.row0 && cur.active)
      col_mem[cur.col] <= new_col;
    else if (stage && out_free && cur.row0)
      col_mem[cur.col] <= '0;
  end

  assign new_col = nmh_pkg::sat_add(rd_data, {{16{cur.sy[31]}}, cur.sy});
  assign new_row = nmh_pkg::sat_add(row_acc, {{16{cur.sx[31]}}, cur.sx});

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= 1'b0;
      hout.valid <= 1'b0;
      row_acc    <= '0;
    end else begin
      if (stage && out_free) hout.valid <= 1'b1;
      else if (hout.ready) hout.valid <= 1'b0;
      if (pop) stage <= 1'b1;
      else if (stage && out_free) begin
        stage <= 1'b0;
        if (cur.col0) row_acc <= '0;
        else if (cur.active) row_acc <= new_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (stage && out_free) begin
      hout.height_value <= cur.active ? nmh_pkg::sat_add(new_row, new_col) : '0;
      hout.end_of_row   <= cur.eor;
      hout.end_of_frame <= cur.eof;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/normal_map_to_height_integrator.sv =====
// ----------------------------------------------------------------------------
// normal_map_to_height_integrator
// Integrates a raster stream of normal-map pixels into a height map.
// ----------------------------------------------------------------------------
// channel   dir  beat
// pix       in   normal_x, normal_y, normal_z
// hout      out  height_value, end_of_row, end_of_frame
// apb       in   frame_width @0x0, frame_height @0x4
//
// For interior pixels, two 33-step passes of the shared bit-serial divider
// set the rate. Row 0 / column 0 pixels skip the divider.
// The back end takes one beat at a time (line buffer read then write back).
// Reset is synchronous; after it the back end zeroes the column line buffer
// in one pass over all 4096 entries while pixels wait in the queue.
// Output stalls back up through a 4-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "normal_map_to_height_integrator_assert.svh"
module normal_map_to_height_integrator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  nmh_pixel_if.sink        pix,
  nmh_height_if.source     hout
);
  logic [nmh_pkg::DimBits-1:0] frame_width, frame_height;
  logic           push, full, pop, not_empty;
  nmh_pkg::work_t push_item, head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd256;
      frame_height <= 13'd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2:1] >> 1)
        nmh_pkg::RegWidth:  frame_width  <= pwdata[12:0];
        nmh_pkg::RegHeight: frame_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2:1] >> 1)
      nmh_pkg::RegWidth:  prdata = {19'd0, frame_width};
      nmh_pkg::RegHeight: prdata = {19'd0, frame_height};
      default:            prdata = '0;
    endcase
  end

  nmh_front u_front (
    .clk, .rst, .frame_width, .frame_height, .pix,
    .push, .push_item, .queue_full(full)
  );

  nmh_queue u_queue (
    .clk, .rst, .push, .push_item, .full, .pop, .head, .not_empty
  );

  nmh_back u_back (
    .clk, .rst, .head, .not_empty, .pop, .hout
  );

  `NMH_ASSERT(a_no_push_full, !(push && full), "push into full queue")
  `NMH_ASSERT_NEXT(a_out_hold, hout.valid && !hout.ready, hout.valid && $stable(hout.height_value), "stalled beat changed")
  `NMH_ASSERT(a_eof_has_eor, !hout.valid || !hout.end_of_frame || hout.end_of_row, "end of frame without end of row")
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams normal-map pixels through the height integrator under random
// backpressure and compares every height beat with an in-bench model of the
// slope math, the row/column running sums and the row/frame markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  localparam longint HMax = 64'sd140737488355327;
  localparam longint HMin = -HMax - 1;
  localparam longint SlMax = 64'sd2147483647;
  localparam longint SlMin = -SlMax - 1;

  typedef struct {
    logic signed [nmh_pkg::SumBits-1:0] height;
    logic                               eor;
    logic                               eof;
  } height_beat_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nmh_pixel_if  pix ();
  nmh_height_if hout ();

  normal_map_to_height_integrator u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix     (pix.sink),
    .hout    (hout.source)
  );

  // model state
  logic [nmh_pkg::DimBits-1:0] cfg_width;
  logic [nmh_pkg::DimBits-1:0] cfg_height;
  longint             row_sum;
  longint             col_sum [nmh_pkg::MaxWidth];
  int unsigned        col_cnt;
  int unsigned        row_cnt;

  height_beat_t expected_heights[$];
  int           errors;
  bit           idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic bit idle_now();
    return idle_en && ($urandom_range(99) < 28);
  endfunction

  function automatic longint centered(logic [15:0] v);
    return 2 * longint'({1'b0, v}) - 65536;
  endfunction

  function automatic longint slope_q16(longint c, longint nz);
    longint q;
    q = (-c * 65536) / nz;
    if (q > SlMax) return SlMax;
    if (q < SlMin) return SlMin;
    return q;
  endfunction

  function automatic longint clip48(longint v);
    if (v > HMax) return HMax;
    if (v < HMin) return HMin;
    return v;
  endfunction

  function automatic int unsigned clamp_dim(logic [nmh_pkg::DimBits-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic predict_height(input logic [15:0] nx, input logic [15:0] ny,
                                input logic [15:0] nzr);
    int unsigned  w;
    int unsigned  h;
    int unsigned  col;
    int unsigned  idx;
    longint       nz;
    longint       hv;
    height_beat_t e;
    w   = clamp_dim(cfg_width, nmh_pkg::MaxWidth);
    h   = clamp_dim(cfg_height, nmh_pkg::MaxHeight);
    col = col_cnt;
    idx = col % nmh_pkg::MaxWidth;
    hv  = 0;
    if (row_cnt == 0) begin
      col_sum[idx] = 0;
      if (col == 0) row_sum = 0;
    end else if (col == 0) begin
      row_sum = 0;
    end else begin
      nz = centered(nzr);
      if (nz < 1) nz = 1;
      row_sum      = clip48(row_sum + slope_q16(centered(nx), nz));
      col_sum[idx] = clip48(col_sum[idx] + slope_q16(centered(ny), nz));
      hv           = clip48(row_sum + col_sum[idx]);
    end
    e.eor    = (col + 1 >= w);
    e.eof    = e.eor && (row_cnt + 1 >= h);
    e.height = hv[nmh_pkg::SumBits-1:0];
    if (e.eor) begin
      col_cnt = 0;
      row_cnt = e.eof ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col + 1;
    end
    expected_heights.push_back(e);
  endtask

  // entered and left at a falling edge
  task automatic send_pixel(input logic [15:0] nx, input logic [15:0] ny,
                            input logic [15:0] nzr);
    while (idle_now()) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid    <= 1'b1;
    pix.normal_x <= nx;
    pix.normal_y <= ny;
    pix.normal_z <= nzr;
    do @(posedge clk); while (!pix.ready);
    predict_height(nx, ny, nzr);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [15:0] z;
    // mostly upward-facing normals, some fully random
    z = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(65535, 32769));
    send_pixel(16'($urandom), 16'($urandom), z);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [nmh_pkg::DimBits-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'({idx, 2'b00});
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == nmh_pkg::RegWidth) cfg_width = val;
    else cfg_height = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (expected_heights.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_frame(input logic [nmh_pkg::DimBits-1:0] w,
                           input logic [nmh_pkg::DimBits-1:0] h);
    drain();
    reg_write(nmh_pkg::RegWidth, w);
    reg_write(nmh_pkg::RegHeight, h);
  endtask

  // sink stall generator
  initial begin
    hout.ready = 1'b0;
    forever begin
      @(negedge clk);
      hout.ready <= (rst || idle_now()) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && hout.valid && hout.ready) begin
      if (expected_heights.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected height beat %0d", hout.height_value);
      end else begin
        height_beat_t e;
        e = expected_heights.pop_front();
        if (hout.height_value !== e.height || hout.end_of_row !== e.eor ||
            hout.end_of_frame !== e.eof) begin
          errors++;
          if (errors <= 10)
            $display("height mismatch: exp h=%0d eor=%b eof=%b got h=%0d eor=%b eof=%b",
                     e.height, e.eor, e.eof, hout.height_value, hout.end_of_row,
                     hout.end_of_frame);
        end
      end
    end
  end

  task automatic test_slope_corners();
    set_frame(13'd4, 13'd3);
    repeat (4) send_random_pixel();     // row 0
    send_pixel(16'h0000, 16'hFFFF, 16'h1234);  // column 0
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);  // nz clamps, slope saturates
    send_pixel(16'h8000, 16'h8000, 16'h8000);  // nz exactly zero
    send_pixel(16'h7FFF, 16'h8001, 16'h8001);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0001, 16'hFFFE, 16'hC000);
  endtask

  task automatic test_dim_limits();
    set_frame(13'd0, 13'd0);            // both treated as one
    repeat (3) send_random_pixel();
    set_frame(13'h1FFF, 13'h1FFF);      // clamp to 4096
    repeat (5) send_random_pixel();
    set_frame(13'd4096, 13'd4096);
    repeat (3) send_random_pixel();
    // shrink mid-frame: counters beyond the new end wrap
    set_frame(13'd1, 13'd5);
    repeat (6) send_random_pixel();
  endtask

  task automatic test_random_frames();
    int sent;
    int w;
    int h;
    sent = 0;
    idle_en = 1'b0;                     // long stretch without gaps
    while (sent < 1620) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(64, 2) : $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      set_frame(13'(w), 13'(h));
      repeat ($urandom_range(3, 1) * w * h) begin
        if (sent < 1620) begin
          send_random_pixel();
          sent++;
        end
      end
      if (sent > 300) idle_en = 1'b1;
    end
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix.valid    = 1'b0;
    pix.normal_x = '0;
    pix.normal_y = '0;
    pix.normal_z = '0;
    errors       = 0;
    idle_en      = 1'b1;
    cfg_width    = 13'd256;
    cfg_height   = 13'd256;
    row_sum      = 0;
    col_cnt      = 0;
    row_cnt      = 0;
    foreach (col_sum[i]) col_sum[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_slope_corners();
    test_dim_limits();
    test_random_frames();
    drain();

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/nmh_pkg.sv
hw/rtl/nmh_stream_if.sv
hw/rtl/nmh_divider.sv
hw/rtl/nmh_front.sv
hw/rtl/nmh_queue.sv
hw/rtl/nmh_back.sv
hw/rtl/normal_map_to_height_integrator.sv
dv/tb_top.sv
